@@ hdl/dtfq_pkg.sv @@
// ----------------------------------------------------------------------------
// dtfq_pkg
// Shared types and constants of the double to fixed-point quantizer.
// ----------------------------------------------------------------------------
package dtfq_pkg;

    localparam int SIG_BITS      = 52;
    localparam int EXP_BITS      = 11;
    localparam int EXP_BIAS      = 1023;
    localparam int SIGN_POS      = 63;
    localparam int WORD_BITS     = 64;
    localparam int FRACTION_BITS_DEF = 48;

    localparam logic [EXP_BITS-1:0] EXP_ALL_ONES = 11'h7FF;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_NON_FINITE = 2'd1;
    localparam status_t ST_RANGE      = 2'd2;

    // stage 1 -> stage 2: decoded operand and shift plan
    typedef struct packed {
        logic        neg;
        logic        special;     // result already decided
        status_t     status;
        logic        left;        // left shift (else right shift with rounding)
        logic [6:0]  amount;      // shift distance, < 64 when used
        logic        drop_all;    // right shift of 64 or more
        logic [52:0] sig;
    } dec_t;

    // stage 2 -> stage 3: magnitude before range check and sign
    typedef struct packed {
        logic        neg;
        logic        special;
        status_t     status;
        logic        over;        // left shift lost bits
        logic [63:0] mag;
    } mag_t;

endpackage

@@ hdl/dtfq_decode.sv @@
// ----------------------------------------------------------------------------
// dtfq_decode
// Splits the binary64 word, flags specials and works out the scaling shift.
// ----------------------------------------------------------------------------
module dtfq_decode #(
    parameter int FRACTION_BITS = dtfq_pkg::FRACTION_BITS_DEF
) (
    input  logic [63:0]    value_bits,
    output dtfq_pkg::dec_t dec
);
    import dtfq_pkg::*;

    logic [EXP_BITS-1:0] bexp;
    logic [51:0]         frac;
    logic signed [12:0]  shift;   // exponent - bias - 52 + FRACTION_BITS

    localparam int SHIFT_OFS = FRACTION_BITS - EXP_BIAS - SIG_BITS;

    always_comb begin
        bexp  = value_bits[62:52];
        frac  = value_bits[51:0];
        dec   = '0;
        dec.neg = value_bits[SIGN_POS];
        dec.sig = {(bexp != '0), frac};
        if (bexp == '0) begin
            shift = 13'(1 + SHIFT_OFS);
        end else begin
            shift = $signed({2'b00, bexp}) + 13'(SHIFT_OFS);
        end
        if (bexp == EXP_ALL_ONES) begin
            dec.special = 1'b1;
            dec.status  = ST_NON_FINITE;
        end else if (dec.sig == '0) begin
            dec.special = 1'b1;
            dec.status  = ST_OK;
        end else if (shift >= 13'sd64) begin
            dec.special = 1'b1;
            dec.status  = ST_RANGE;
        end
        dec.left = (shift >= 13'sd0);
        if (dec.left) begin
            dec.amount   = shift[6:0];
            dec.drop_all = 1'b0;
        end else begin
            dec.amount   = 7'(-shift);
            dec.drop_all = (shift <= -13'sd64);
        end
    end

endmodule

@@ hdl/dtfq_shift.sv @@
// ----------------------------------------------------------------------------
// dtfq_shift
// Scales the significand: left shift with overflow detect, or right shift
// with round half away from zero.
// ----------------------------------------------------------------------------
module dtfq_shift (
    input  dtfq_pkg::dec_t dec,
    output dtfq_pkg::mag_t mg
);
    import dtfq_pkg::*;

    logic [127:0] wide;
    logic [64:0]  rsh_ext;   // shifted significand, bit just below the cut in bit 0

    always_comb begin
        mg         = '0;
        mg.neg     = dec.neg;
        mg.special = dec.special;
        mg.status  = dec.status;
        wide       = {75'd0, dec.sig} << dec.amount[5:0];
        rsh_ext    = {11'd0, dec.sig, 1'b0} >> dec.amount[5:0];
        if (dec.left) begin
            mg.mag  = wide[63:0];
            mg.over = (wide[127:64] != '0);
        end else if (dec.drop_all) begin
            mg.mag  = '0;
        end else begin
            mg.mag  = rsh_ext[64:1] + {63'd0, rsh_ext[0]};
        end
    end

endmodule

@@ hdl/dtfq_finish.sv @@
// ----------------------------------------------------------------------------
// dtfq_finish
// Range check against the int64 limits, sign application, status select.
// ----------------------------------------------------------------------------
module dtfq_finish (
    input  dtfq_pkg::mag_t   mg,
    output logic [63:0]      fixed_value,
    output dtfq_pkg::status_t status
);
    import dtfq_pkg::*;

    logic too_big;

    always_comb begin
        too_big = mg.over ||
                  (mg.neg ? (mg.mag > 64'h8000_0000_0000_0000) : mg.mag[63]);
        fixed_value = '0;
        if (mg.special) begin
            status = mg.status;
        end else if (too_big) begin
            status = ST_RANGE;
        end else begin
            status      = ST_OK;
            fixed_value = mg.neg ? (64'd0 - mg.mag) : mg.mag;
        end
    end

endmodule

@@ hdl/double_to_fixed_quantizer_core.sv @@
// ----------------------------------------------------------------------------
// double_to_fixed_quantizer_core
// IEEE-754 binary64 to signed 64-bit fixed point, round half away from zero.
// ----------------------------------------------------------------------------
// One word in and one word out per cycle while m_ready is high, through a
// three-stage pipeline (decode, scale/round, range/sign); an accepted word is
// registered in dec_reg, then mag_reg, then val_reg, which drives m_valid.
// Each stage has its own enable and loads when it is empty or the stage
// after it moves, so bubbles close up under backpressure; s_ready drops only
// when all three stages hold words and m_ready is low.
// Status 0 ok, 1 infinity/NaN, 2 out of range; value is 0 unless ok.
module double_to_fixed_quantizer_core #(
    parameter int FRACTION_BITS = dtfq_pkg::FRACTION_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [63:0]        s_value_bits,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_fixed_value,
    output dtfq_pkg::status_t  m_status
);
    import dtfq_pkg::*;

    dec_t        dec_next, dec_reg;
    mag_t        mag_next, mag_reg;
    logic [63:0] val_next, val_reg;
    status_t     st_next, st_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        en3, en2, en1;

    dtfq_decode #(.FRACTION_BITS(FRACTION_BITS)) u_dec (
        .value_bits(s_value_bits), .dec(dec_next));
    dtfq_shift  u_sh  (.dec(dec_reg), .mg(mag_next));
    dtfq_finish u_fin (.mg(mag_reg), .fixed_value(val_next), .status(st_next));

    assign en3     = !v3_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) dec_reg <= dec_next;
        if (en2) mag_reg <= mag_next;
        if (en3) begin
            val_reg <= val_next;
            st_reg  <= st_next;
        end
    end

    assign m_valid       = v3_reg;
    assign m_fixed_value = val_reg;
    assign m_status      = st_reg;

    // a non-ok word always carries a zero value
    a_zero_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_fixed_value == '0)
        else $error("nonzero value with error status");

    a_no_code3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("status code 3 produced");

    // stalled output word must hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fixed_value))
        else $error("output word changed under stall");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted word not in stage one");

endmodule
